### hw/rtl/rfd_pkg.sv
// ----------------------------------------------------------------------------
// rfd_pkg
// Shared types and constants for the request frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package rfd_pkg;

    localparam int BYTE_W      = 8;
    localparam int INT_W       = 32;
    localparam int ACC_W       = 24;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 8;

    // bytes in one integer element
    localparam logic [BYTE_W-1:0] INT_BYTES = 8'd4;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_INT_TYPE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STR_TYPE = 8'd1;

    localparam logic [BYTE_W-1:0] INT_TYPE_RESET = 8'd1;
    localparam logic [BYTE_W-1:0] STR_TYPE_RESET = 8'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INTEGER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STRING  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_END     = 2'd3;

    // frame status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_LENGTH    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LIST_TYPE = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_TRUNCATED = 2'd3;

    // output tdata width: 67 bits of fields, padded to whole bytes
    localparam int OUT_FIELDS_W = 2 * BYTE_W + INT_W + BYTE_W + 1 + BYTE_W + STATUS_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef struct packed {
        logic [KIND_W-1:0]    item_kind;
        logic [BYTE_W-1:0]    message_type;
        logic [BYTE_W-1:0]    message_command;
        logic signed [INT_W-1:0] int_value;
        logic [BYTE_W-1:0]    text_byte;
        logic                 string_done;
        logic [BYTE_W-1:0]    arg_number;
        logic                 frame_done;
        logic [STATUS_W-1:0]  frame_status;
    } result_t;

    typedef struct packed {
        logic [BYTE_W-1:0] int_type_code;
        logic [BYTE_W-1:0] str_type_code;
    } type_codes_t;

endpackage : rfd_pkg

`default_nettype wire

### hw/rtl/rfd_parser.sv
// ----------------------------------------------------------------------------
// rfd_parser
// Frame parse state; turns each accepted byte into at most one result.
// ----------------------------------------------------------------------------
`default_nettype none

module rfd_parser
    import rfd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               byte_valid,
    input  wire logic [BYTE_W-1:0]  data_byte,
    input  wire logic               frame_last,
    input  wire type_codes_t        codes,
    output logic                    result_valid,
    output result_t                 result
);

    typedef enum logic [2:0] {
        PH_LENGTH  = 3'd0,
        PH_TYPE    = 3'd1,
        PH_COMMAND = 3'd2,
        PH_MARKER  = 3'd3,
        PH_LTYPE   = 3'd4,
        PH_COUNT   = 3'd5,
        PH_ELEMENT = 3'd6,
        PH_DISCARD = 3'd7
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [BYTE_W-1:0]   byte_count_reg, byte_count_next;
    logic [BYTE_W-1:0]   declared_length_reg, declared_length_next;
    logic [BYTE_W-1:0]   held_type_reg, held_type_next;
    logic                list_is_string_reg, list_is_string_next;
    logic [BYTE_W-1:0]   items_left_reg, items_left_next;
    logic [BYTE_W-1:0]   elem_left_reg, elem_left_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [BYTE_W-1:0]   arg_counter_reg, arg_counter_next;
    logic [STATUS_W-1:0] error_reg, error_next;

    logic                elem_done;
    logic [BYTE_W-1:0]   items_dec;

    always_comb
    begin
        phase_next           = phase_reg;
        byte_count_next      = byte_count_reg;
        declared_length_next = declared_length_reg;
        held_type_next       = held_type_reg;
        list_is_string_next  = list_is_string_reg;
        items_left_next      = items_left_reg;
        elem_left_next       = elem_left_reg;
        acc_next             = acc_reg;
        arg_counter_next     = arg_counter_reg;
        error_next           = error_reg;
        elem_done            = 1'b0;
        items_dec            = items_left_reg - 8'd1;
        result_valid         = 1'b0;
        result               = '0;

        // byte count saturates; one more byte flags a length mismatch
        if (byte_count_reg == 8'hFF)
            error_next = STATUS_LENGTH;
        else
            byte_count_next = byte_count_reg + 8'd1;

        case (phase_reg)
            PH_LENGTH:
            begin
                declared_length_next = data_byte;
                phase_next           = PH_TYPE;
            end
            PH_TYPE:
            begin
                held_type_next = data_byte;
                phase_next     = PH_COMMAND;
            end
            PH_COMMAND:
            begin
                result_valid           = 1'b1;
                result.item_kind       = KIND_HEADER;
                result.message_type    = held_type_reg;
                result.message_command = data_byte;
                phase_next             = PH_MARKER;
            end
            PH_MARKER:
            begin
                phase_next = PH_LTYPE;
            end
            PH_LTYPE:
            begin
                held_type_next = data_byte;
                phase_next     = PH_COUNT;
            end
            PH_COUNT:
            begin
                items_left_next  = data_byte;
                arg_counter_next = '0;
                if (data_byte == '0)
                    phase_next = PH_MARKER;
                else if (held_type_reg == codes.int_type_code)
                begin
                    list_is_string_next = 1'b0;
                    elem_left_next      = INT_BYTES;
                    phase_next          = PH_ELEMENT;
                end
                else if (held_type_reg == codes.str_type_code)
                begin
                    list_is_string_next = 1'b1;
                    elem_left_next      = '0;
                    phase_next          = PH_ELEMENT;
                end
                else
                begin
                    if (error_next == STATUS_OK)
                        error_next = STATUS_LIST_TYPE;
                    phase_next = PH_DISCARD;
                end
            end
            PH_ELEMENT:
            begin
                if (list_is_string_reg)
                begin
                    if (elem_left_reg == '0)
                    begin
                        // string length byte; zero means an empty string
                        if (data_byte == '0)
                            elem_done = 1'b1;
                        else
                            elem_left_next = data_byte;
                    end
                    else
                    begin
                        result_valid       = 1'b1;
                        result.item_kind   = KIND_STRING;
                        result.text_byte   = data_byte;
                        result.arg_number  = arg_counter_reg;
                        result.string_done = (elem_left_reg == 8'd1);
                        elem_left_next     = elem_left_reg - 8'd1;
                        elem_done          = (elem_left_reg == 8'd1);
                    end
                end
                else if (elem_left_reg > 8'd1)
                begin
                    acc_next       = {acc_reg[ACC_W-BYTE_W-1:0], data_byte};
                    elem_left_next = elem_left_reg - 8'd1;
                end
                else
                begin
                    result_valid      = 1'b1;
                    result.item_kind  = KIND_INTEGER;
                    result.arg_number = arg_counter_reg;
                    result.int_value  = {acc_reg, data_byte};
                    elem_done         = 1'b1;
                end
            end
            default:
            begin
                // discarding to frame end
            end
        endcase

        if (elem_done)
        begin
            items_left_next  = items_dec;
            arg_counter_next = arg_counter_reg + 8'd1;
            if (items_dec == '0)
                phase_next = PH_MARKER;
            else
                elem_left_next = list_is_string_reg ? '0 : INT_BYTES;
        end

        if (frame_last)
        begin
            result.frame_done = 1'b1;
            if (error_next == STATUS_LENGTH || byte_count_next != declared_length_next)
                result.frame_status = STATUS_LENGTH;
            else if (error_next == STATUS_LIST_TYPE)
                result.frame_status = STATUS_LIST_TYPE;
            else if (phase_next != PH_MARKER)
                result.frame_status = STATUS_TRUNCATED;
            else
                result.frame_status = STATUS_OK;
            if (!result_valid)
                result.item_kind = KIND_END;
            result_valid = 1'b1;

            phase_next           = PH_LENGTH;
            byte_count_next      = '0;
            declared_length_next = '0;
            held_type_next       = '0;
            list_is_string_next  = 1'b0;
            items_left_next      = '0;
            elem_left_next       = '0;
            acc_next             = '0;
            arg_counter_next     = '0;
            error_next           = STATUS_OK;
        end

        result_valid = result_valid & byte_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_LENGTH;
            byte_count_reg      <= '0;
            declared_length_reg <= '0;
            held_type_reg       <= '0;
            list_is_string_reg  <= 1'b0;
            items_left_reg      <= '0;
            elem_left_reg       <= '0;
            acc_reg             <= '0;
            arg_counter_reg     <= '0;
            error_reg           <= STATUS_OK;
        end
        else if (byte_valid)
        begin
            phase_reg           <= phase_next;
            byte_count_reg      <= byte_count_next;
            declared_length_reg <= declared_length_next;
            held_type_reg       <= held_type_next;
            list_is_string_reg  <= list_is_string_next;
            items_left_reg      <= items_left_next;
            elem_left_reg       <= elem_left_next;
            acc_reg             <= acc_next;
            arg_counter_reg     <= arg_counter_next;
            error_reg           <= error_next;
        end
    end

endmodule : rfd_parser

`default_nettype wire

### hw/rtl/rfd_out_buf.sv
// ----------------------------------------------------------------------------
// rfd_out_buf
// Two-entry result register; keeps the input side moving while the
// downstream side stalls, until both entries are full.
// ----------------------------------------------------------------------------
`default_nettype none

module rfd_out_buf
    import rfd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         space,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    result_t     entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg, count_next;
    logic        pop;

    assign space     = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid & out_ready;

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule : rfd_out_buf

`default_nettype wire

### hw/rtl/request_frame_deframer.sv
// ----------------------------------------------------------------------------
// request_frame_deframer
// Parses a byte stream of request frames into header, integer and
// string-byte items, with a status on the last byte of each frame.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake           Payload
// s_*      in   s_tvalid/s_tready   s_tdata = data_byte, s_tlast = frame_last
// m_*      out  m_tvalid/m_tready   m_tdata, m_tuser = item_kind,
//                                   m_tlast = frame_done
// cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// One byte per cycle when s_tready is high. Each byte updates the parse state
// in the cycle it is accepted and its item (if any) lands in a two-entry
// output register, reaching m_* after older items. s_tready drops only when
// both output entries are full. cfg_ready is always high. Reset returns the
// parse state to frame start and the type codes to 1 (integer), 2 (string).
// ----------------------------------------------------------------------------
`default_nettype none

module request_frame_deframer
    import rfd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [BYTE_W-1:0]      s_tdata,   // [7:0] data_byte
    input  wire logic                   s_tlast,   // frame_last

    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [7:0] message_type, [15:8] message_command, [47:16] int_value,
    // [55:48] text_byte, [56] string_done, [64:57] arg_number,
    // [66:65] frame_status, [71:67] zero
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    output logic [KIND_W-1:0]           m_tuser,   // [1:0] item_kind
    output logic                        m_tlast,   // frame_done

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]      cfg_data
);

    type_codes_t codes_reg;
    logic        byte_valid;
    logic        result_valid;
    result_t     result;
    logic        space;
    result_t     out_data;

    assign cfg_ready  = 1'b1;
    assign s_tready   = space;
    assign byte_valid = s_tvalid & space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_reg.int_type_code <= INT_TYPE_RESET;
            codes_reg.str_type_code <= STR_TYPE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_INT_TYPE: codes_reg.int_type_code <= cfg_data;
                CFG_STR_TYPE: codes_reg.str_type_code <= cfg_data;
                default:      codes_reg <= codes_reg;
            endcase
        end
    end

    rfd_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .data_byte    (s_tdata),
        .frame_last   (s_tlast),
        .codes        (codes_reg),
        .result_valid (result_valid),
        .result       (result)
    );

    rfd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (result_valid),
        .push_data (result),
        .space     (space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {
        {(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
        out_data.frame_status,
        out_data.arg_number,
        out_data.string_done,
        out_data.text_byte,
        out_data.int_value,
        out_data.message_command,
        out_data.message_type
    };
    assign m_tuser = out_data.item_kind;
    assign m_tlast = out_data.frame_done;

endmodule : request_frame_deframer

`default_nettype wire

### bench/request_frame_deframer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// request_frame_deframer_tb
// Drives byte-stream request frames into the deframer and checks every item
// it emits against a cycle-free decoder kept in the bench. Covers good frames,
// cut, mis-sized, over-long and noise frames, unknown list types, empty lists
// and strings, under several type-code settings with random stalls both sides.
// ----------------------------------------------------------------------------

module request_frame_deframer_tb;
    import rfd_pkg::*;

    typedef enum logic [2:0] {
        PH_LENGTH, PH_MSG_TYPE, PH_COMMAND, PH_MARKER,
        PH_LIST_TYPE, PH_COUNT, PH_ELEMENT, PH_DISCARD
    } frame_phase_e;

    typedef enum int {
        SHAPE_GOOD, SHAPE_CUT, SHAPE_BAD_LENGTH, SHAPE_ODD_TYPE,
        SHAPE_NOISE, SHAPE_LONG, SHAPE_FULL
    } frame_shape_e;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
        int unsigned       gap;
        bit                drain;   // hold until all results are back
    } src_byte_t;

    typedef logic [BYTE_W-1:0] byte_list_t[$];

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]      m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]      cfg_data;

    // decoder state kept by the bench
    frame_phase_e      fr_phase;
    logic [BYTE_W-1:0] fr_count;
    logic [BYTE_W-1:0] fr_length;
    logic [BYTE_W-1:0] fr_type;
    logic              fr_is_str;
    logic [BYTE_W-1:0] fr_left;
    logic [BYTE_W-1:0] fr_elem_left;
    logic [ACC_W-1:0]  fr_acc;
    logic [BYTE_W-1:0] fr_arg;
    logic [STATUS_W-1:0] fr_err;
    logic [BYTE_W-1:0] code_int;
    logic [BYTE_W-1:0] code_str;

    src_byte_t   tx_bytes[$];
    result_t     pending_results[$];
    src_byte_t   next_byte;
    bit          have_next = 1'b0;
    int unsigned src_wait = 0;
    int unsigned sink_wait = 0;
    bit          sink_idle = 1'b1;
    logic        byte_taken = 1'b0;
    logic        result_taken = 1'b0;

    int fail_count = 0;
    int results_checked = 0;
    int bytes_taken = 0;
    int frames_sent = 0;
    int phase_bytes = 0;
    int settings_run = 0;

    request_frame_deframer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void clear_frame_state();
        fr_phase     = PH_LENGTH;
        fr_count     = '0;
        fr_length    = '0;
        fr_type      = '0;
        fr_is_str    = 1'b0;
        fr_left      = '0;
        fr_elem_left = '0;
        fr_acc       = '0;
        fr_arg       = '0;
        fr_err       = STATUS_OK;
    endfunction

    function automatic void close_element();
        fr_left = fr_left - 8'd1;
        fr_arg  = fr_arg + 8'd1;
        if (fr_left == 8'd0)
            fr_phase = PH_MARKER;
        else
            fr_elem_left = fr_is_str ? 8'd0 : INT_BYTES;
    endfunction

    // Advances the frame decoder by one byte; returns 1 when an item is due.
    function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic last,
                                       output result_t r);
        bit hit;
        hit = 1'b0;
        r   = '0;
        if (fr_count == 8'hFF)
            fr_err = STATUS_LENGTH;
        else
            fr_count = fr_count + 8'd1;

        case (fr_phase)
            PH_LENGTH:
            begin
                fr_length = b;
                fr_phase  = PH_MSG_TYPE;
            end
            PH_MSG_TYPE:
            begin
                fr_type  = b;
                fr_phase = PH_COMMAND;
            end
            PH_COMMAND:
            begin
                hit                 = 1'b1;
                r.item_kind         = KIND_HEADER;
                r.message_type      = fr_type;
                r.message_command   = b;
                fr_phase            = PH_MARKER;
            end
            PH_MARKER:
                fr_phase = PH_LIST_TYPE;
            PH_LIST_TYPE:
            begin
                fr_type  = b;
                fr_phase = PH_COUNT;
            end
            PH_COUNT:
            begin
                fr_left = b;
                fr_arg  = '0;
                if (b == 8'd0)
                    fr_phase = PH_MARKER;
                else if (fr_type == code_int)
                begin
                    // integer wins when both codes match
                    fr_is_str    = 1'b0;
                    fr_elem_left = INT_BYTES;
                    fr_phase     = PH_ELEMENT;
                end
                else if (fr_type == code_str)
                begin
                    fr_is_str    = 1'b1;
                    fr_elem_left = 8'd0;
                    fr_phase     = PH_ELEMENT;
                end
                else
                begin
                    if (fr_err == STATUS_OK)
                        fr_err = STATUS_LIST_TYPE;
                    fr_phase = PH_DISCARD;
                end
            end
            PH_ELEMENT:
            begin
                if (fr_is_str)
                begin
                    if (fr_elem_left == 8'd0)
                    begin
                        // length byte; zero means an empty string
                        if (b == 8'd0)
                            close_element();
                        else
                            fr_elem_left = b;
                    end
                    else
                    begin
                        hit           = 1'b1;
                        r.item_kind   = KIND_STRING;
                        r.text_byte   = b;
                        r.arg_number  = fr_arg;
                        r.string_done = (fr_elem_left == 8'd1);
                        fr_elem_left  = fr_elem_left - 8'd1;
                        if (fr_elem_left == 8'd0)
                            close_element();
                    end
                end
                else if (fr_elem_left > 8'd1)
                begin
                    fr_acc       = {fr_acc[ACC_W-BYTE_W-1:0], b};
                    fr_elem_left = fr_elem_left - 8'd1;
                end
                else
                begin
                    hit          = 1'b1;
                    r.item_kind  = KIND_INTEGER;
                    r.arg_number = fr_arg;
                    r.int_value  = {fr_acc, b};
                    close_element();
                end
            end
            default: ;
        endcase

        if (last)
        begin
            r.frame_done = 1'b1;
            if (fr_err == STATUS_LENGTH || fr_count != fr_length)
                r.frame_status = STATUS_LENGTH;
            else if (fr_err == STATUS_LIST_TYPE)
                r.frame_status = STATUS_LIST_TYPE;
            else if (fr_phase != PH_MARKER)
                r.frame_status = STATUS_TRUNCATED;
            else
                r.frame_status = STATUS_OK;
            if (!hit)
            begin
                hit         = 1'b1;
                r.item_kind = KIND_END;
            end
            clear_frame_state();
        end
        return hit;
    endfunction

    task automatic check_field(input string name, input logic [INT_W-1:0] want,
                               input logic [INT_W-1:0] got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= 50)
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    // Byte source: one new item per accepted item, after its drawn gap.
    always @(negedge clk)
    begin
        if (rst_n && !(s_tvalid && !byte_taken))
        begin
            if (!have_next && tx_bytes.size() != 0)
            begin
                next_byte = tx_bytes.pop_front();
                have_next = 1'b1;
                src_wait  = next_byte.gap;
            end
            if (have_next && src_wait == 0 &&
                !(next_byte.drain && pending_results.size() != 0))
            begin
                s_tvalid  <= 1'b1;
                s_tdata   <= next_byte.data;
                s_tlast   <= next_byte.last;
                have_next = 1'b0;
            end
            else
            begin
                s_tvalid <= 1'b0;
                if (have_next && src_wait != 0)
                    src_wait = src_wait - 1;
            end
        end
    end

    // Result sink: a fresh stall is drawn after every item taken while sink_idle is set.
    always @(negedge clk)
    begin : sink_ready
        int unsigned stall;
        if (rst_n)
        begin
            stall = sink_wait;
            if (result_taken)
                stall = sink_idle ? $urandom_range(0, 19) : 0;
            if (stall != 0)
            begin
                m_tready  <= 1'b0;
                sink_wait = stall - 1;
            end
            else
            begin
                m_tready  <= 1'b1;
                sink_wait = 0;
            end
        end
    end

    // Checks results first, then predicts from the byte taken on this edge.
    always @(posedge clk)
    begin : observe
        result_t got;
        result_t want;
        result_t pred;
        if (rst_n)
        begin
            result_taken <= m_tvalid && m_tready;
            byte_taken   <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                got.item_kind       = m_tuser;
                got.message_type    = m_tdata[7:0];
                got.message_command = m_tdata[15:8];
                got.int_value       = m_tdata[47:16];
                got.text_byte       = m_tdata[55:48];
                got.string_done     = m_tdata[56];
                got.arg_number      = m_tdata[64:57];
                got.frame_status    = m_tdata[66:65];
                got.frame_done      = m_tlast;
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 50)
                        $display("%0t: item with none expected, expected nothing, got kind %0d",
                                 $time, got.item_kind);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("item_kind", want.item_kind, got.item_kind);
                    check_field("message_type", want.message_type, got.message_type);
                    check_field("message_command", want.message_command,
                                got.message_command);
                    check_field("int_value", want.int_value, got.int_value);
                    check_field("text_byte", want.text_byte, got.text_byte);
                    check_field("string_done", want.string_done, got.string_done);
                    check_field("arg_number", want.arg_number, got.arg_number);
                    check_field("frame_done", want.frame_done, got.frame_done);
                    check_field("frame_status", want.frame_status, got.frame_status);
                    results_checked++;
                    if (results_checked % 32 == 0)
                        sink_idle = $urandom_range(0, 2) != 0;
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (decode_byte(s_tdata, s_tlast, pred))
                    pending_results.insert(pending_results.size(), pred);
                bytes_taken++;
            end
        end
    end

    task automatic queue_frame(input byte_list_t bytes, input bit hold_first);
        src_byte_t it;
        bit        idle;
        idle = $urandom_range(0, 2) != 0;
        foreach (bytes[i])
        begin
            it.data  = bytes[i];
            it.last  = (i == bytes.size() - 1);
            it.gap   = idle ? $urandom_range(0, 19) : 0;
            it.drain = hold_first && (i == 0);
            tx_bytes.insert(tx_bytes.size(), it);
        end
        frames_sent++;
        phase_bytes += bytes.size();
    endtask

    task automatic queue_random_frame(input frame_shape_e shape, input bit hold_first);
        byte_list_t        body;
        logic [BYTE_W-1:0] lt;
        logic [INT_W-1:0]  v;
        int                n_lists;
        int                cnt;
        int                slen;
        int                pick;
        body = {};
        if (shape == SHAPE_NOISE)
        begin
            repeat ($urandom_range(1, 12))
                body.insert(body.size(), 8'($urandom));
            queue_frame(body, hold_first);
            return;
        end
        body.insert(body.size(), 8'($urandom));
        body.insert(body.size(), 8'($urandom));
        n_lists = (shape == SHAPE_LONG || shape == SHAPE_FULL) ? 1 : $urandom_range(0, 3);
        if (shape == SHAPE_ODD_TYPE && n_lists == 0)
            n_lists = 1;
        for (int l = 0; l < n_lists; l++)
        begin
            body.insert(body.size(), 8'($urandom));
            pick = $urandom_range(0, 9);
            cnt  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
            if (shape == SHAPE_ODD_TYPE && l == 0)
            begin
                do
                    lt = 8'($urandom);
                while (lt == code_int || lt == code_str);
                cnt = $urandom_range(1, 3);
            end
            else if (shape == SHAPE_FULL)
            begin
                lt  = code_str;
                cnt = 1;
            end
            else if (shape == SHAPE_LONG)
            begin
                lt  = code_int;
                cnt = $urandom_range(65, 70);
            end
            else if (pick < 4)
                lt = code_int;
            else if (pick < 8)
                lt = code_str;
            else
                lt = 8'($urandom);
            body.insert(body.size(), lt);
            body.insert(body.size(), 8'(cnt));
            for (int e = 0; e < cnt; e++)
            begin
                if (lt == code_int)
                begin
                    case ($urandom_range(0, 5))
                        0:       v = 32'h8000_0000;
                        1:       v = 32'h7FFF_FFFF;
                        2:       v = '1;
                        3:       v = '0;
                        default: v = $urandom;
                    endcase
                    for (int k = 3; k >= 0; k--)
                        body.insert(body.size(), v[8*k +: 8]);
                end
                else if (lt == code_str)
                begin
                    if (shape == SHAPE_FULL)
                        slen = 248;     // frame lands on exactly 255 bytes
                    else
                        slen = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
                    body.insert(body.size(), 8'(slen));
                    repeat (slen)
                        body.insert(body.size(), 8'($urandom));
                end
                else
                    body.insert(body.size(), 8'($urandom));
            end
        end
        if (shape == SHAPE_CUT)
            repeat ($urandom_range(1, body.size()))
                void'(body.pop_back());
        if (shape == SHAPE_BAD_LENGTH)
            body.push_front(8'(body.size() + 1 + $urandom_range(1, 255)));
        else if (shape == SHAPE_LONG)
            body.push_front(8'($urandom));
        else
            body.push_front(8'(body.size() + 1));
        queue_frame(body, hold_first);
    endtask

    task automatic write_type_code(input logic [CFG_INDEX_W-1:0] idx,
                                   input logic [BYTE_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_INT_TYPE)
            code_int = val;
        else
            code_str = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every byte is in and every result out.
    task automatic settle();
        while (tx_bytes.size() != 0 || have_next || s_tvalid || pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin : stimulus
        byte_list_t        frame;
        logic [BYTE_W-1:0] set_int;
        logic [BYTE_W-1:0] set_str;
        int                r;
        frame_shape_e      shape;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        clear_frame_state();
        code_int = INT_TYPE_RESET;
        code_str = STR_TYPE_RESET;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // integer min, empty string, short string, empty list of unknown type
        frame = '{8'd20, 8'hFF, 8'h00, 8'hAA, INT_TYPE_RESET, 8'd1,
                  8'h80, 8'h00, 8'h00, 8'h00, 8'h55, STR_TYPE_RESET, 8'd2,
                  8'h00, 8'h02, 8'h41, 8'h00, 8'h00, 8'h09, 8'h00};
        queue_frame(frame, 1'b0);
        // length byte disagrees with the bytes sent
        frame = '{8'd4, 8'h00, 8'hFF};
        queue_frame(frame, 1'b0);
        // nonempty list of unknown type
        frame = '{8'd6, 8'h01, 8'h01, 8'h00, 8'h33, 8'h01};
        queue_frame(frame, 1'b0);
        // ends inside a list header
        frame = '{8'd5, 8'h10, 8'h20, 8'hFF, 8'h01};
        queue_frame(frame, 1'b0);
        settle();
        settings_run = 1;

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    set_int = 8'h00;
                    set_str = 8'hFF;
                end
                1:
                begin
                    set_int = 8'hFF;
                    set_str = 8'h00;
                end
                2:
                begin
                    set_int = 8'h07;
                    set_str = 8'h07;
                end
                5:
                begin
                    set_int = INT_TYPE_RESET;
                    set_str = STR_TYPE_RESET;
                end
                default:
                begin
                    set_int = 8'($urandom);
                    set_str = 8'($urandom);
                end
            endcase
            write_type_code(CFG_INT_TYPE, set_int);
            write_type_code(CFG_STR_TYPE, set_str);
            settings_run++;
            phase_bytes = 0;
            if (p == 5)
            begin
                queue_random_frame(SHAPE_FULL, 1'b0);
                queue_random_frame(SHAPE_LONG, 1'b0);
            end
            while (phase_bytes < 190)
            begin
                r = $urandom_range(0, 99);
                if (r < 72)
                    shape = SHAPE_GOOD;
                else if (r < 80)
                    shape = SHAPE_CUT;
                else if (r < 86)
                    shape = SHAPE_BAD_LENGTH;
                else if (r < 92)
                    shape = SHAPE_ODD_TYPE;
                else if (r < 99)
                    shape = SHAPE_NOISE;
                else
                    shape = SHAPE_LONG;
                queue_random_frame(shape, phase_bytes == 0 || $urandom_range(0, 24) == 0);
            end
            settle();
        end

        $display("Checked %0d items from %0d bytes in %0d frames", results_checked,
                 bytes_taken, frames_sent);
        $display("over %0d type-code settings, with good, cut, bad and oversized frames.",
                 settings_run);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### sim.f
hw/rtl/rfd_pkg.sv
hw/rtl/rfd_parser.sv
hw/rtl/rfd_out_buf.sv
hw/rtl/request_frame_deframer.sv
bench/request_frame_deframer_tb.sv
